>>> design/hhle_pkg.sv
// ----------------------------------------------------------------------------
// hhle_pkg
// Types and constants of the HTTP header length extractor: event codes,
// result status codes, register indexes, parse phases and the key text.
// ----------------------------------------------------------------------------
package hhle_pkg;

    // Event carried by one input item.
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_CLOSE = 1'b1;

    // Configuration register indexes.
    localparam logic REG_MAX_BODY   = 1'b0;
    localparam logic REG_MAX_HEADER = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_LEN  = 2'd1;
    localparam logic [1:0] ST_CLOSED  = 2'd2;

    localparam logic [23:0] MAX_BODY_RESET   = 24'd65536;
    localparam logic [12:0] MAX_HEADER_RESET = 13'd4096;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_TAB = 8'd9;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;

    localparam int          KEY_LEN   = 16;
    localparam logic [24:0] VALUE_SAT = 25'h1FF_FFFF;

    // Progress through the value after the key.
    typedef enum logic [3:0] {
        PH_SEARCH = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    // Lower-case text of "Content-Length: ".
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:  c = "c";
            4'd1:  c = "o";
            4'd2:  c = "n";
            4'd3:  c = "t";
            4'd4:  c = "e";
            4'd5:  c = "n";
            4'd6:  c = "t";
            4'd7:  c = "-";
            4'd8:  c = "l";
            4'd9:  c = "e";
            4'd10: c = "n";
            4'd11: c = "g";
            4'd12: c = "t";
            4'd13: c = "h";
            4'd14: c = ":";
            4'd15: c = " ";
            default: c = " ";
        endcase
        return c;
    endfunction

endpackage

>>> design/http_header_length_extractor.sv
// ----------------------------------------------------------------------------
// http_header_length_extractor
// Finds the end of an HTTP header and the value of its Content-Length field,
// one header byte per item, and reports one result per header.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  input     in         in_valid / in_stall    action, data_byte
//  result    out        out_valid / out_stall  status, body_length, truncated
//  config    in         cfg_write              cfg_index, cfg_data
//
// An item is taken into an input register and processed while the skid entry
// is empty; one item per cycle is sustained in that case, and the result is registered
// as its item is processed. The matcher and accumulator update is one short step.
// Reset clears the per-header state and loads the default limits.
// A two-entry result buffer lets input continue while one result is stalled;
// in_stall rises only when both entries are full and an item is waiting.
// ----------------------------------------------------------------------------
module http_header_length_extractor
    import hhle_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [23:0] body_length,
    output logic        truncated,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int LIMIT_CAP = (MAX_HEADER_BYTES < 8191) ? MAX_HEADER_BYTES : 8191;
    localparam int CNT_W     = $clog2(LIMIT_CAP + 1);

    // Configuration registers.
    logic [23:0] max_body_reg;
    logic [12:0] max_header_reg;

    // Input register.
    logic        stage_valid_reg;
    logic        stage_action_reg;
    logic [7:0]  stage_byte_reg;

    // Per-header state.
    logic [1:0]       term_reg, term_next;
    logic [4:0]       key_reg, key_next;
    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [24:0]      len_reg, len_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             stopped_reg, stopped_next;

    // Result buffer: output entry and skid entry.
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [23:0] out_body_reg;
    logic        out_trunc_reg;
    logic        skid_valid_reg;
    logic [1:0]  skid_status_reg;
    logic [23:0] skid_body_reg;
    logic        skid_trunc_reg;

    logic        in_accept;
    logic        stage_go;
    logic        res_valid;
    logic [1:0]  res_status;
    logic [23:0] res_body;
    logic        res_trunc;
    logic        push;
    logic        pop;

    logic [7:0]       b;
    logic [7:0]       folded;
    logic             is_space;
    logic             is_digit;
    logic [28:0]      len_times_ten;
    logic [28:0]      len_candidate;
    logic [1:0]       term_inc;
    logic             term_match;
    logic             by_end;
    logic             ended;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] count_inc;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = stage_valid_reg && skid_valid_reg;
    assign stage_go  = stage_valid_reg && !skid_valid_reg;
    assign pop       = out_valid_reg && !out_stall;
    assign push      = stage_go && res_valid;

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign body_length = out_body_reg;
    assign truncated   = out_trunc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg   <= MAX_BODY_RESET;
            max_header_reg <= MAX_HEADER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAX_BODY:   max_body_reg   <= cfg_data;
                REG_MAX_HEADER: max_header_reg <= cfg_data[12:0];
                default:        max_body_reg   <= max_body_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (stage_go)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_action_reg <= action;
            stage_byte_reg   <= data_byte;
        end
    end

    // Byte classification and the times-ten step of the value.
    assign b      = stage_byte_reg;
    assign folded = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + 8'd32 : b;
    assign is_space = (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
    assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign len_times_ten = {1'b0, len_reg, 3'b000} + {3'b000, len_reg, 1'b0};
    assign len_candidate = len_times_ten + {21'd0, b - CHAR_ZERO};

    // The terminator alternates CR and LF.
    assign term_match = (b == (term_reg[0] ? CHAR_LF : CHAR_CR));
    assign term_inc   = term_reg + 2'd1;
    assign by_end     = term_match && (term_reg == 2'd3);

    assign limit = (max_header_reg > 13'(LIMIT_CAP)) ? CNT_W'(LIMIT_CAP)
                                                     : CNT_W'(max_header_reg);
    assign count_inc = count_reg + CNT_W'(1);
    assign ended     = by_end || (count_inc >= limit);

    always_comb
    begin
        term_next    = term_reg;
        key_next     = key_reg;
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        res_valid    = 1'b0;
        res_status   = ST_OK;
        res_body     = 24'd0;
        res_trunc    = 1'b0;

        if (stage_action_reg == ACT_CLOSE)
        begin
            res_valid  = 1'b1;
            res_status = ST_CLOSED;
        end
        else
        begin
            count_next = count_inc;
            if (term_match)
            begin
                term_next = term_inc;
            end
            else
            begin
                term_next = (b == CHAR_CR) ? 2'd1 : 2'd0;
            end

            if (!stopped_reg && phase_reg != PH_DONE)
            begin
                if (b == 8'd0)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_SEARCH:
                        begin
                            if (folded == key_char(key_reg[3:0]))
                            begin
                                key_next = key_reg + 5'd1;
                            end
                            else
                            begin
                                key_next = (folded == key_char(4'd0)) ? 5'd1 : 5'd0;
                            end
                            if (key_next == 5'(KEY_LEN))
                            begin
                                phase_next = PH_SIGN;
                            end
                        end
                        PH_SIGN:
                        begin
                            // A sign or a digit starts the digits; any other non-space byte ends the value.
                            if (b == CHAR_PLUS || b == CHAR_MINUS)
                            begin
                                neg_next   = (b == CHAR_MINUS);
                                phase_next = PH_DIGITS;
                            end
                            else if (!is_space)
                            begin
                                if (is_digit)
                                begin
                                    len_next   = len_candidate[24:0];
                                    phase_next = PH_DIGITS;
                                end
                                else
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                len_next = (len_candidate > {4'd0, VALUE_SAT})
                                         ? VALUE_SAT : len_candidate[24:0];
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_DONE:
                        begin
                            phase_next = PH_DONE;
                        end
                        default:
                        begin
                            phase_next = PH_DONE;
                        end
                    endcase
                end
            end

            if (ended)
            begin
                res_valid = 1'b1;
                res_trunc = !by_end;
                if (len_next == 25'd0 || neg_next)
                begin
                    res_status = ST_NO_LEN;
                end
                else
                begin
                    res_status = ST_OK;
                    res_body   = (len_next > {1'b0, max_body_reg})
                               ? max_body_reg : len_next[23:0];
                end
            end
        end

        if (res_valid)
        begin
            term_next    = 2'd0;
            key_next     = 5'd0;
            phase_next   = PH_SEARCH;
            neg_next     = 1'b0;
            len_next     = 25'd0;
            count_next   = '0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg    <= 2'd0;
            key_reg     <= 5'd0;
            phase_reg   <= PH_SEARCH;
            neg_reg     <= 1'b0;
            len_reg     <= 25'd0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else if (stage_go)
        begin
            term_reg    <= term_next;
            key_reg     <= key_next;
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_status_reg <= skid_status_reg;
                out_body_reg   <= skid_body_reg;
                out_trunc_reg  <= skid_trunc_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_status_reg <= res_status;
                out_body_reg   <= res_body;
                out_trunc_reg  <= res_trunc;
            end
            else
            begin
                skid_status_reg <= res_status;
                skid_body_reg   <= res_body;
                skid_trunc_reg  <= res_trunc;
            end
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output entry is empty");

    a_body_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> (out_body_reg == 24'd0))
        else $error("nonzero body length with a failing status");

    a_closed_not_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_CLOSED) |-> !out_trunc_reg)
        else $error("close result flagged as truncated");

    a_count_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(LIMIT_CAP))
        else $error("header byte count passed the limit");
`endif

endmodule

>>> tb/header_length_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// header_length_checker
// Watches the input, result and configuration ports of the HTTP header length
// extractor. It keeps its own model of the header parser, works out the report
// due for each header that ends or is closed, and compares every delivered
// report with the oldest one still due.
// ----------------------------------------------------------------------------
module header_length_checker
    import hhle_pkg::*;
#(
    parameter int HEADER_CAP = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [23:0] body_length,
    input  logic        truncated,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    output int          errors,
    output int          reports_due,
    output int          reports_seen
);

    localparam logic [127:0] KEY_TEXT = "content-length: ";

    typedef struct packed {
        logic [1:0]  code;
        logic [23:0] length;
        logic        cut;
    } report_t;

    report_t     header_reports[$];
    logic [23:0] body_max;
    logic [12:0] header_max;
    logic [1:0]  crlf_matched;
    logic [4:0]  key_matched;
    phase_t      value_phase;
    logic        value_negative;
    logic [24:0] value_mag;
    logic [12:0] header_bytes;
    logic        scan_stopped;

    function automatic logic [7:0] key_at(input int pos);
        return KEY_TEXT[127 - 8 * pos -: 8];
    endfunction

    task automatic start_header();
        crlf_matched   = '0;
        key_matched    = '0;
        value_phase    = PH_SEARCH;
        value_negative = 1'b0;
        value_mag      = '0;
        header_bytes   = '0;
        scan_stopped   = 1'b0;
    endtask

    // Key search first, then the value as atoi reads it.
    task automatic scan_length_byte(input logic [7:0] b);
        logic [7:0]  folded;
        int unsigned digit;
        if (scan_stopped || value_phase == PH_DONE)
        begin
            return;
        end
        if (b == 8'h00)
        begin
            scan_stopped = 1'b1;
            return;
        end
        if (value_phase == PH_SEARCH)
        begin
            // Only upper-case letters fold; 32 is the distance to lower case.
            folded = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + 8'd32 : b;
            if (key_matched < KEY_LEN && folded == key_at(key_matched))
            begin
                key_matched++;
            end
            else
            begin
                key_matched = (folded == key_at(0)) ? 5'd1 : 5'd0;
            end
            if (key_matched >= KEY_LEN)
            begin
                value_phase = PH_SIGN;
            end
            return;
        end
        if (value_phase == PH_SIGN)
        begin
            if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))
            begin
                return;
            end
            value_phase = PH_DIGITS;
            if (b == CHAR_PLUS || b == CHAR_MINUS)
            begin
                value_negative = (b == CHAR_MINUS);
                return;
            end
        end
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            digit = {24'd0, b - CHAR_ZERO};
            if (value_mag > (VALUE_SAT - digit) / 10)
            begin
                value_mag = VALUE_SAT;
            end
            else
            begin
                value_mag = 25'(value_mag * 10 + digit);
            end
        end
        else
        begin
            value_phase = PH_DONE;
        end
    endtask

    task automatic parse_item(input logic act, input logic [7:0] b);
        logic [2:0] crlf_next;
        logic       by_terminator;
        int         limit;
        report_t    rep;
        if (act == ACT_CLOSE)
        begin
            rep = '{ST_CLOSED, 24'd0, 1'b0};
            header_reports.push_back(rep);
            start_header();
            return;
        end
        header_bytes++;
        if (b == (crlf_matched[0] ? CHAR_LF : CHAR_CR))
        begin
            crlf_next = {1'b0, crlf_matched} + 3'd1;
        end
        else
        begin
            crlf_next = (b == CHAR_CR) ? 3'd1 : 3'd0;
        end
        by_terminator = (crlf_next == 3'd4);
        crlf_matched  = crlf_next[1:0];
        scan_length_byte(b);
        limit = (header_max > HEADER_CAP) ? HEADER_CAP : int'(header_max);
        if (!by_terminator && header_bytes < limit)
        begin
            return;
        end
        if (value_mag == '0 || value_negative)
        begin
            rep = '{ST_NO_LEN, 24'd0, !by_terminator};
        end
        else
        begin
            rep = '{ST_OK, (value_mag > body_max) ? body_max : value_mag[23:0], !by_terminator};
        end
        header_reports.push_back(rep);
        start_header();
    endtask

    always @(posedge clk)
    begin
        report_t want;
        if (!rst_n)
        begin
            body_max   = MAX_BODY_RESET;
            header_max = MAX_HEADER_RESET;
            start_header();
            header_reports.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                reports_seen++;
                if (header_reports.size() == 0)
                begin
                    $error("report with none due: status %0d, body_length %0d, truncated %0d",
                           status, body_length, truncated);
                    errors++;
                end
                else
                begin
                    want = header_reports.pop_front();
                    if (status !== want.code)
                    begin
                        $error("status: expected %0d, got %0d", want.code, status);
                        errors++;
                    end
                    if (body_length !== want.length)
                    begin
                        $error("body_length: expected %0d, got %0d", want.length, body_length);
                        errors++;
                    end
                    if (truncated !== want.cut)
                    begin
                        $error("truncated: expected %0d, got %0d", want.cut, truncated);
                        errors++;
                    end
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_MAX_BODY)
                begin
                    body_max = cfg_data;
                end
                else
                begin
                    header_max = cfg_data[12:0];
                end
            end
            if (in_valid && !in_stall)
            begin
                parse_item(action, data_byte);
            end
        end
        reports_due = header_reports.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the HTTP header length extractor: directed corner headers,
// then phases of random headers under different limits, with random gaps on
// both channels and one long hold on the result side. The checker beside the
// block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
    import hhle_pkg::*;

    localparam int HDR_CAP      = 4096;
    localparam int LONG_HOLD    = 60;
    localparam int PHASE_ITEMS  = 100;
    localparam int ITEM_TARGET  = 1100;
    localparam int REPORT_FLOOR = 50;
    localparam int SETTLE       = 6;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [23:0] body_length;
    logic        truncated;
    logic        cfg_write;
    logic        cfg_index;
    logic [23:0] cfg_data;

    int          errors;
    int          reports_due;
    int          reports_seen;
    int          items_sent;
    logic        tx_quiet;
    logic        rx_quiet;
    int          long_hold_req;
    logic [7:0]  header_text[$];

    http_header_length_extractor #(
        .MAX_HEADER_BYTES(HDR_CAP)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .body_length(body_length),
        .truncated(truncated),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    header_length_checker #(
        .HEADER_CAP(HDR_CAP)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .body_length(body_length),
        .truncated(truncated),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors),
        .reports_due(reports_due),
        .reports_seen(reports_seen)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #(10_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: a random hold before each report, plus one long hold on request.
    initial
    begin
        int hold;
        int holds_taken;
        holds_taken = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = rx_quiet ? 0 : $urandom_range(0, 6);
            if (long_hold_req != holds_taken)
            begin
                hold += LONG_HOLD;
                holds_taken++;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_item(input logic act, input logic [7:0] b);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid  <= 1'b0;
            action    <= 1'($urandom_range(0, 1));
            data_byte <= 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Lets in-flight items finish so that no item is processed under a changed limit.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (reports_due != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_limits(input logic [23:0] body_max, input logic [12:0] header_max);
        cfg_write <= 1'b1;
        cfg_index <= REG_MAX_BODY;
        cfg_data  <= body_max;
        @(negedge clk);
        cfg_index <= REG_MAX_HEADER;
        cfg_data  <= {11'd0, header_max};
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            header_text.push_back(s[i]);
        end
    endtask

    // The key in random letter case; a broken key stops early on a wrong byte.
    task automatic add_key(input bit broken);
        string      key_line;
        int         stop;
        logic [7:0] c;
        key_line = "content-length: ";
        stop = broken ? $urandom_range(1, 15) : 16;
        for (int i = 0; i < stop; i++)
        begin
            c = key_line[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
            begin
                c = c - 8'd32;
            end
            header_text.push_back(c);
        end
        if (broken)
        begin
            header_text.push_back("x");
        end
    endtask

    task automatic add_value();
        int sign_pick;
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 3))
                0, 1:    header_text.push_back(CHAR_SPACE);
                2:       header_text.push_back(CHAR_TAB);
                default: header_text.push_back(8'($urandom_range(CHAR_TAB, CHAR_CR)));
            endcase
        end
        sign_pick = $urandom_range(0, 9);
        if (sign_pick < 2)
        begin
            header_text.push_back(CHAR_PLUS);
        end
        else if (sign_pick < 4)
        begin
            header_text.push_back(CHAR_MINUS);
        end
        // Long digit strings drive the value into saturation.
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6))
        begin
            header_text.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            add_text(" x");
        end
    endtask

    task automatic add_line();
        case ($urandom_range(0, 4))
            0: add_text("Content-Type: text/html");
            1: add_text("Host: h");
            2: add_text("content-lengt: 9");
            3: add_text("GET /a HTTP/1.1");
            default:
            begin
                repeat ($urandom_range(1, 12)) header_text.push_back(8'($urandom_range(33, 126)));
            end
        endcase
        add_text("\r\n");
    endtask

    task automatic send_text();
        for (int i = 0; i < header_text.size(); i++)
        begin
            send_item(ACT_BYTE, header_text[i]);
        end
    endtask

    task automatic send_header();
        int kind;
        int cut;
        bit closing;
        header_text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 88)
        begin
            repeat ($urandom_range(0, 2)) add_line();
            if (kind < 62)
            begin
                add_key(1'b0);
                add_value();
                add_text("\r\n");
            end
            else if (kind < 72)
            begin
                add_key(1'b1);
                add_text("\r\n");
            end
            if ($urandom_range(0, 1) == 1)
            begin
                add_line();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                header_text.insert($urandom_range(0, header_text.size()), 8'h00);
            end
            add_text("\r\n");
        end
        else
        begin
            repeat ($urandom_range(1, 24)) header_text.push_back(8'($urandom_range(0, 255)));
        end
        closing = ($urandom_range(0, 14) == 0);
        cut = closing ? $urandom_range(0, header_text.size()) : header_text.size();
        for (int i = 0; i < cut; i++)
        begin
            send_item(ACT_BYTE, header_text[i]);
        end
        if (closing)
        begin
            send_item(ACT_CLOSE, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int          phase;
        int          phase_start;
        logic [23:0] body_max;
        logic [12:0] header_max;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_BYTE;
        data_byte     = 8'h00;
        cfg_write     = 1'b0;
        cfg_index     = REG_MAX_BODY;
        cfg_data      = 24'd0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        long_hold_req = 0;
        items_sent    = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // A close before any byte of a header.
        send_item(ACT_CLOSE, 8'hFF);
        wait_idle();
        // With a zero limit every byte is a header of its own.
        set_limits(MAX_BODY_RESET, 13'd0);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BYTE, 8'h00);
        wait_idle();
        // The key ends exactly at the limit, so the value is empty.
        set_limits(24'd1, 13'd16);
        header_text.delete();
        add_key(1'b0);
        send_text();
        wait_idle();
        // Terminator and limit land on the same byte.
        set_limits(24'hFF_FFFF, 13'd4);
        header_text.delete();
        add_text("\r\n\r\n");
        send_text();
        wait_idle();

        phase = 0;
        while (phase < 6 ||
               ((items_sent < ITEM_TARGET || reports_seen < REPORT_FLOOR) && phase < 40))
        begin
            case (phase)
                0: set_limits(MAX_BODY_RESET, MAX_HEADER_RESET);
                1: set_limits(24'd0, 13'd4096);
                2: set_limits(24'hFF_FFFF, 13'h1FFF);
                3: set_limits(24'd1, 13'd4);
                4: set_limits(24'd9999, 13'd40);
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       body_max = 24'($urandom_range(0, 300));
                        1:       body_max = 24'($urandom_range(0, 24'hFF_FFFF));
                        2:       body_max = 24'($urandom_range(1, 100000));
                        default: body_max = 24'hFF_FFFF;
                    endcase
                    header_max = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                                             : 13'($urandom_range(4, 80));
                    set_limits(body_max, header_max);
                end
            endcase
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                // Closes keep coming while the result side holds off, filling the block.
                long_hold_req++;
                repeat (12) send_item(ACT_CLOSE, 8'($urandom_range(0, 255)));
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                send_header();
            end
            wait_idle();
            phase++;
        end

        if (errors == 0 && reports_due == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
